@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the tag stripper checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while reset is released.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while reset is released.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pts_pkg.sv @@
// ----------------------------------------------------------------------------
// pts_pkg
// Types, character codes and tag prefix table for the tag stripper.
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int PREFIX_LEN_DEF  = 6;

    localparam logic [15:0] CH_LT    = 16'h003C;
    localparam logic [15:0] CH_GT    = 16'h003E;
    localparam logic [15:0] CH_SPACE = 16'h0020;
    localparam logic [15:0] CH_NL    = 16'h000A;
    localparam logic [15:0] CH_US    = 16'h005F;
    localparam logic [15:0] CH_P     = 16'h0070;
    localparam logic [15:0] CH_D     = 16'h0064;
    localparam logic [15:0] CH_F     = 16'h0066;
    localparam logic [15:0] CH_NUL   = 16'h0000;

    typedef struct packed {
        logic [15:0] text_char;
        logic        end_of_text;
    } in_t;

    typedef struct packed {
        logic [15:0] kept_char;
        logic [23:0] source_offset;
        logic        has_char;
        logic        run_last;
        logic        text_done;
    } out_t;

    typedef struct packed {
        logic load;
        logic eot;
    } batch_ctl_t;

    // Tag prefix "<_pdf " padded with NUL.
    function automatic logic [15:0] tag_char(input int idx);
        logic [15:0] c;
        case (idx)
            0:       c = CH_LT;
            1:       c = CH_US;
            2:       c = CH_P;
            3:       c = CH_D;
            4:       c = CH_F;
            5:       c = CH_SPACE;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // True when the prefix shifted by 'shift' agrees with its own head for 'len' chars.
    function automatic logic self_match(input int shift, input int len);
        logic ok;
        ok = 1'b1;
        for (int j = 0; j < 16; j++) begin
            if (j < len && tag_char(shift + j) != tag_char(j)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

@@ sv/pts_window.sv @@
// ----------------------------------------------------------------------------
// pts_window
// Lookahead window and tag tracking: turns each accepted char into a batch
// of released chars with their source offsets.
// ----------------------------------------------------------------------------
module pts_window #(
    parameter int OFFSET_BITS = pts_pkg::OFFSET_BITS_DEF,
    parameter int PREFIX_LEN  = pts_pkg::PREFIX_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                acc,
    input  pts_pkg::in_t                        in_data,
    output pts_pkg::batch_ctl_t                 ld_ctl,
    output logic [$clog2(PREFIX_LEN+1)-1:0]     ld_cnt,
    output logic [15:0]                         ld_chars [PREFIX_LEN],
    output logic [OFFSET_BITS-1:0]              ld_offs  [PREFIX_LEN]
);

    localparam int BW = $clog2(PREFIX_LEN + 1);
    localparam int CW = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   inside_reg, inside_next;
    logic [OFFSET_BITS-1:0] ioff_reg, ioff_next;
    logic [OFFSET_BITS-1:0] woff_reg  [PREFIX_LEN];
    logic [OFFSET_BITS-1:0] woff_next [PREFIX_LEN];
    logic [OFFSET_BITS-1:0] wo        [PREFIX_LEN];

    logic [15:0]            ch;
    logic                   eot;
    logic [BW-1:0]          n;
    logic [BW-1:0]          sel;
    logic [BW-1:0]          npop;
    logic [PREFIX_LEN-1:0]  ok;
    logic                   enter;

    assign ch  = in_data.text_char;
    assign eot = in_data.end_of_text;

    always_comb begin
        n  = BW'(cnt_reg) + BW'(1);
        ok = '0;
        // Window head is always a prefix of the tag; only the new char varies.
        for (int s = 0; s < PREFIX_LEN; s++) begin
            for (int cv = 0; cv < PREFIX_LEN; cv++) begin
                if (s <= cv && pts_pkg::self_match(s, cv - s) && cnt_reg == CW'(cv)
                    && ch == pts_pkg::tag_char(cv - s)) begin
                    ok[s] = 1'b1;
                end
            end
        end
        // Smallest shift that leaves a matching window; the rest is released.
        sel = n;
        for (int s = PREFIX_LEN - 1; s >= 0; s--) begin
            if (ok[s]) begin
                sel = BW'(s);
            end
        end
        enter = ok[0] && (cnt_reg == CW'(PREFIX_LEN - 1));

        for (int j = 0; j < PREFIX_LEN; j++) begin
            if (j < int'(cnt_reg)) begin
                wo[j]       = woff_reg[j];
                ld_chars[j] = pts_pkg::tag_char(j);
            end else begin
                wo[j]       = ioff_reg;
                ld_chars[j] = ch;
            end
        end
        ld_offs = wo;

        for (int k = 0; k < PREFIX_LEN; k++) begin
            woff_next[k] = woff_reg[k];
            for (int sv = 0; sv < PREFIX_LEN - k; sv++) begin
                if (int'(sel) == sv) begin
                    woff_next[k] = wo[k + sv];
                end
            end
        end

        if (inside_reg) begin
            npop = '0;
        end else if (eot && !enter) begin
            npop = n;
        end else begin
            npop = sel;
        end

        if (ioff_reg != {OFFSET_BITS{1'b1}}) begin
            ioff_next = ioff_reg + OFFSET_BITS'(1);
        end else begin
            ioff_next = ioff_reg;
        end

        if (inside_reg) begin
            inside_next = (ch != pts_pkg::CH_GT);
            cnt_next    = '0;
        end else if (enter) begin
            inside_next = 1'b1;
            cnt_next    = '0;
        end else begin
            inside_next = 1'b0;
            cnt_next    = CW'(n - sel);
        end

        // End of text returns the window to its reset state.
        if (eot) begin
            inside_next = 1'b0;
            cnt_next    = '0;
            ioff_next   = '0;
        end
    end

    assign ld_cnt      = npop;
    assign ld_ctl.load = acc && (npop != '0 || eot);
    assign ld_ctl.eot  = eot;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            inside_reg <= 1'b0;
            ioff_reg   <= '0;
        end else if (acc) begin
            cnt_reg    <= cnt_next;
            inside_reg <= inside_next;
            ioff_reg   <= ioff_next;
            woff_reg   <= woff_next;
        end
    end

endmodule

@@ sv/pts_emit.sv @@
// ----------------------------------------------------------------------------
// pts_emit
// Batch drain: applies held-space rules one char per cycle unless the result
// channel stalls; drives the registered result channel with last and done flags.
// ----------------------------------------------------------------------------
module pts_emit #(
    parameter int OFFSET_BITS = pts_pkg::OFFSET_BITS_DEF,
    parameter int PREFIX_LEN  = pts_pkg::PREFIX_LEN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  pts_pkg::batch_ctl_t                 ld_ctl,
    input  logic [$clog2(PREFIX_LEN+1)-1:0]     ld_cnt,
    input  logic [15:0]                         ld_chars [PREFIX_LEN],
    input  logic [OFFSET_BITS-1:0]              ld_offs  [PREFIX_LEN],
    output logic                                take,
    output logic                                m_valid,
    input  logic                                m_ready,
    output pts_pkg::out_t                       m_data
);

    localparam int BW       = $clog2(PREFIX_LEN + 1);
    localparam int CW       = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;
    localparam int TAIL_IDX = (PREFIX_LEN > 1) ? 1 : 0;

    logic                   bvld_reg;
    logic                   beot_reg;
    logic [BW-1:0]          bcnt_reg;
    logic [15:0]            bch_reg  [PREFIX_LEN];
    logic [OFFSET_BITS-1:0] boff_reg [PREFIX_LEN];
    logic                   sp_reg, sp_next;
    logic [OFFSET_BITS-1:0] spoff_reg, spoff_next;
    logic                   mvld_reg;
    pts_pkg::out_t          mdat_reg;

    logic [15:0]            head;
    logic [OFFSET_BITS-1:0] hoff;
    logic                   has_head;
    logic                   emit, e_has, consume;
    logic [15:0]            e_char;
    logic [OFFSET_BITS-1:0] e_off;
    logic [BW-1:0]          rem, nsp, lidx_full;
    logic                   any_ns, last_sp, r_empty, final_pend, more, tail, finish, adv;

    assign head      = bch_reg[0];
    assign hoff      = boff_reg[0];
    assign has_head  = (bcnt_reg != '0);
    assign lidx_full = bcnt_reg - BW'(1);

    always_comb begin
        emit       = 1'b0;
        e_has      = 1'b1;
        consume    = 1'b0;
        e_char     = pts_pkg::CH_NUL;
        e_off      = '0;
        sp_next    = sp_reg;
        spoff_next = spoff_reg;

        if (has_head) begin
            if (head == pts_pkg::CH_SPACE) begin
                consume    = 1'b1;
                emit       = sp_reg;
                e_char     = pts_pkg::CH_SPACE;
                e_off      = spoff_reg;
                sp_next    = 1'b1;
                spoff_next = hoff;
            end else if (head == pts_pkg::CH_NL) begin
                consume = 1'b1;
                emit    = 1'b1;
                e_char  = head;
                e_off   = hoff;
                sp_next = 1'b0;
            end else if (sp_reg) begin
                // release the held space first, keep the char for the next step
                emit    = 1'b1;
                e_char  = pts_pkg::CH_SPACE;
                e_off   = spoff_reg;
                sp_next = 1'b0;
            end else begin
                consume = 1'b1;
                emit    = 1'b1;
                e_char  = head;
                e_off   = hoff;
            end
        end else begin
            // end of text step: held space or empty marker
            emit    = 1'b1;
            sp_next = 1'b0;
            if (sp_reg) begin
                e_char = pts_pkg::CH_SPACE;
                e_off  = spoff_reg;
            end else begin
                e_has = 1'b0;
            end
        end

        rem    = bcnt_reg - BW'(consume);
        any_ns = 1'b0;
        nsp    = '0;
        for (int i = 0; i < PREFIX_LEN; i++) begin
            if (i >= int'(consume) && i < int'(bcnt_reg)) begin
                if (bch_reg[i] != pts_pkg::CH_SPACE) begin
                    any_ns = 1'b1;
                end else begin
                    nsp = nsp + BW'(1);
                end
            end
        end
        last_sp    = has_head && (bch_reg[lidx_full[CW-1:0]] == pts_pkg::CH_SPACE);
        r_empty    = (rem == '0);
        final_pend = r_empty ? sp_next : last_sp;
        more       = has_head && (any_ns || nsp >= BW'(2) || (nsp == BW'(1) && sp_next)
                     || (beot_reg && final_pend));
        // a lone trailing space emits nothing now: hold it for the next batch
        tail       = emit && !more && !r_empty;
        finish     = emit ? !more : (r_empty && !beot_reg);

        if (tail) begin
            sp_next    = 1'b1;
            spoff_next = boff_reg[TAIL_IDX];
        end
        if (finish && beot_reg) begin
            sp_next = 1'b0;
        end
    end

    assign adv  = bvld_reg && (!mvld_reg || m_ready);
    assign take = !bvld_reg || (adv && finish);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvld_reg  <= 1'b0;
            beot_reg  <= 1'b0;
            bcnt_reg  <= '0;
            sp_reg    <= 1'b0;
            spoff_reg <= '0;
            mvld_reg  <= 1'b0;
        end else begin
            if (adv && emit) begin
                mvld_reg <= 1'b1;
            end else if (m_ready) begin
                mvld_reg <= 1'b0;
            end
            if (adv) begin
                sp_reg    <= sp_next;
                spoff_reg <= spoff_next;
                if (consume) begin
                    bcnt_reg <= rem;
                    for (int i = 0; i < PREFIX_LEN - 1; i++) begin
                        bch_reg[i]  <= bch_reg[i + 1];
                        boff_reg[i] <= boff_reg[i + 1];
                    end
                end
                if (emit) begin
                    mdat_reg.kept_char     <= e_char;
                    mdat_reg.source_offset <= 24'(e_off);
                    mdat_reg.has_char      <= e_has;
                    mdat_reg.run_last      <= !more;
                    mdat_reg.text_done     <= beot_reg && !more;
                end
                if (finish) begin
                    bvld_reg <= 1'b0;
                end
            end
            // load wins over drain of the finishing batch
            if (ld_ctl.load) begin
                bvld_reg <= 1'b1;
                beot_reg <= ld_ctl.eot;
                bcnt_reg <= ld_cnt;
                bch_reg  <= ld_chars;
                boff_reg <= ld_offs;
            end
        end
    end

    assign m_valid = mvld_reg;
    assign m_data  = mdat_reg;

endmodule

@@ sv/pdf_tag_stripper.sv @@
// ----------------------------------------------------------------------------
// pdf_tag_stripper
// Streaming remover of "<_pdf ...>" markers with held-space cleanup.
// ----------------------------------------------------------------------------
// Input channel s_*: one UTF-16 code unit per item, end_of_text on the last.
// Result channel m_*: kept code units with their offsets in the source text;
// run_last flags the last result of an input item, text_done the last one of
// the text, and an item with has_char 0 is the empty end marker.
// The first result of an item passes through the batch register and then the
// result register. Throughput: the drain stage delivers one result per cycle
// while the receiver does not stall. An end of text that releases only a held
// space or the empty marker still takes a drain step for that result. Items
// that release nothing do not occupy the drain stage once it is free. The
// drain stage holds one batch of up to PREFIX_LEN released chars; the next
// item is accepted in the cycle that batch completes.
// When the receiver stalls, the result register holds and the drain stage
// stops; s_ready drops once a new batch cannot be taken.
// Reset (aresetn low, synchronous) clears the window, tag state, offset
// counter, held space and both valid flags; no results are pending after it.
// ----------------------------------------------------------------------------
module pdf_tag_stripper #(
    parameter int OFFSET_BITS = pts_pkg::OFFSET_BITS_DEF,
    parameter int PREFIX_LEN  = pts_pkg::PREFIX_LEN_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pts_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pts_pkg::out_t  m_data
);

    localparam int BW = $clog2(PREFIX_LEN + 1);

    pts_pkg::batch_ctl_t    ld_ctl;
    logic [BW-1:0]          ld_cnt;
    logic [15:0]            ld_chars [PREFIX_LEN];
    logic [OFFSET_BITS-1:0] ld_offs  [PREFIX_LEN];
    logic                   take;
    logic                   acc;

    assign s_ready = take;
    assign acc     = s_valid && take;

    pts_window #(
        .OFFSET_BITS (OFFSET_BITS),
        .PREFIX_LEN  (PREFIX_LEN)
    ) u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (acc),
        .in_data  (s_data),
        .ld_ctl   (ld_ctl),
        .ld_cnt   (ld_cnt),
        .ld_chars (ld_chars),
        .ld_offs  (ld_offs)
    );

    pts_emit #(
        .OFFSET_BITS (OFFSET_BITS),
        .PREFIX_LEN  (PREFIX_LEN)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_ctl   (ld_ctl),
        .ld_cnt   (ld_cnt),
        .ld_chars (ld_chars),
        .ld_offs  (ld_offs),
        .take     (take),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

@@ sv/pts_checker.sv @@
// ----------------------------------------------------------------------------
// pts_checker
// Port-level assertions for the tag stripper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pts_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input pts_pkg::in_t  s_data,
    input logic          m_valid,
    input logic          m_ready,
    input pts_pkg::out_t m_data
);

    // stalled result holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // the final result of a text is also the last of its item
    `ASSERT_IMPL(a_done_last, aclk, aresetn, m_valid && m_data.text_done, m_data.run_last, "text_done without run_last")

    // empty marker only ends a text and carries zero payload
    `ASSERT_IMPL(a_marker, aclk, aresetn, m_valid && !m_data.has_char, m_data.text_done && m_data.kept_char == 16'h0000 && m_data.source_offset == 24'h000000, "malformed end marker")

    // reset leaves no result pending
    `ASSERT_NEXT_ALWAYS(a_reset, aclk, !aresetn, !m_valid, "result valid after reset")

endmodule

bind pdf_tag_stripper pts_checker u_pts_checker (.*);
